// ===== rtl/wfgd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfgd_pkg
// Shared codes, widths and control/status types for the wait-for-graph
// deadlock detector.
// ----------------------------------------------------------------------------
package wfgd_pkg;

    localparam int CMD_W  = 3;
    localparam int TID_W  = 32;
    localparam int ADDR_W = 48;
    localparam int KEY_W  = ADDR_W + 1;
    localparam int STS_W  = 2;

    localparam logic [CMD_W-1:0] OP_WAIT    = 3'd0;
    localparam logic [CMD_W-1:0] OP_ACQUIRE = 3'd1;
    localparam logic [CMD_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [CMD_W-1:0] OP_CLEAR   = 3'd3;
    localparam logic [CMD_W-1:0] OP_CHECK   = 3'd4;

    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_THR_FULL  = 2'd1;
    localparam logic [STS_W-1:0] ST_RES_FULL  = 2'd2;
    localparam logic [STS_W-1:0] ST_UNKNOWN   = 2'd3;

    typedef struct packed {
        logic             load;
        logic             tidx_inc;
        logic             ridx_inc;
        logic             rd_tkey;
        logic             rd_rkey;
        logic             rd_wait;
        logic             rd_own;
        logic             tnew;
        logic             rnew;
        logic             wait_clr;
        logic             wait_set;
        logic             wait_clr_match;
        logic             own_set;
        logic             own_clr;
        logic             cur_load;
        logic             walk_step;
        logic             res_load;
        logic             res_deadlock;
        logic [STS_W-1:0] res_status;
        logic             out_set;
    } wfgd_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             tend;
        logic             tfull;
        logic             tmatch;
        logic             rend;
        logic             rfull;
        logic             rmatch;
        logic             wait_act;
        logic             own_act;
        logic             moves_done;
        logic             out_busy;
    } wfgd_sts_t;

endpackage

// ===== rtl/wait_for_graph_deadlock_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detector
// Tracks thread waits and resource owners and checks a thread for a cycle
// in the wait-for graph.
//
// Usage: one request enters on the s_ channel (command, thread, resource
// address in s_tdata, resource kind in s_tuser) and one result leaves on the
// m_ channel (deadlock bit and status in m_tdata). One request is in work at
// a time; s_tready is high only while the sequencer is idle.
// A thread lookup scans the thread table entry by entry, reading and then
// comparing each stored entry, and a resource lookup likewise scans the
// resource table. An acquire then reads the thread's wait entry and writes
// the owner and wait entries. A check adds the walk, at most THREADS steps,
// each reading the wait entry and then the owner entry. Each table memory
// port gives one read per cycle, which sets the scan pace.
// Reset empties both tables at once through their fill counts; no clearing
// pass is needed. While m_tready is low the finished result is held in the
// output register and the next request is taken only after it leaves.
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_detector
    import wfgd_pkg::*;
#(
    parameter int THREADS   = 64,
    parameter int RESOURCES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // command, thread_id, resource_address, pad
    input  logic        s_tuser,   // resource_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // deadlock, status, pad
);

    wfgd_cmd_t        cmd;
    wfgd_sts_t        sts;
    logic             deadlock;
    logic [STS_W-1:0] status;

    wfgd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wfgd_dpath #(
        .THREADS   (THREADS),
        .RESOURCES (RESOURCES)
    ) u_dpath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_command          (s_tdata[2:0]),
        .in_thread_id        (s_tdata[34:3]),
        .in_resource_address (s_tdata[82:35]),
        .in_resource_kind    (s_tuser),
        .cmd                 (cmd),
        .sts                 (sts),
        .m_tready            (m_tready),
        .m_tvalid            (m_tvalid),
        .out_deadlock        (deadlock),
        .out_status          (status)
    );

    assign m_tdata = {5'd0, status, deadlock};

endmodule

// ===== rtl/wfgd_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfgd_dpath
// Thread and resource tables, scan indexes, walk registers and result
// register of the deadlock detector.
// ----------------------------------------------------------------------------
module wfgd_dpath
    import wfgd_pkg::*;
#(
    parameter int THREADS   = 64,
    parameter int RESOURCES = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CMD_W-1:0]  in_command,
    input  logic [TID_W-1:0]  in_thread_id,
    input  logic [ADDR_W-1:0] in_resource_address,
    input  logic              in_resource_kind,
    input  wfgd_cmd_t         cmd,
    output wfgd_sts_t         sts,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic              out_deadlock,
    output logic [STS_W-1:0]  out_status
);

    localparam int TW  = $clog2(THREADS);
    localparam int RW  = $clog2(RESOURCES);
    localparam int TCW = $clog2(THREADS + 1);
    localparam int RCW = $clog2(RESOURCES + 1);

    logic [TID_W-1:0] tkey_mem [THREADS];
    logic [RW:0]      wait_mem [THREADS];
    logic [KEY_W-1:0] rkey_mem [RESOURCES];
    logic [TW:0]      own_mem  [RESOURCES];

    logic [TID_W-1:0] tkey_q;
    logic [KEY_W-1:0] rkey_q;
    logic [RW:0]      wait_q;
    logic [TW:0]      own_q;

    logic [CMD_W-1:0] op_reg;
    logic [TID_W-1:0] tid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [TCW-1:0]   tcount_reg;
    logic [RCW-1:0]   rcount_reg;
    logic [TCW-1:0]   tidx_reg;
    logic [RCW-1:0]   ridx_reg;
    logic [TW-1:0]    cur_reg;
    logic [TCW-1:0]   moves_reg;
    logic             out_valid_reg;
    logic             deadlock_reg;
    logic [STS_W-1:0] status_reg;

    logic             wait_we;
    logic [RW:0]      wait_wd;
    logic             own_we;
    logic [TW:0]      own_wd;
    logic             wait_match;

    assign wait_match = wait_q[RW] && (wait_q[RW-1:0] == ridx_reg[RW-1:0]);
    assign wait_we = cmd.tnew || cmd.wait_clr || cmd.wait_set
                     || (cmd.wait_clr_match && wait_match);
    assign wait_wd = cmd.wait_set ? {1'b1, ridx_reg[RW-1:0]} : '0;
    assign own_we  = cmd.rnew || cmd.own_clr || cmd.own_set;
    assign own_wd  = cmd.own_set ? {1'b1, tidx_reg[TW-1:0]} : '0;

    always_ff @(posedge aclk) begin
        if (cmd.tnew) begin
            tkey_mem[tidx_reg[TW-1:0]] <= tid_reg;
        end
        if (wait_we) begin
            wait_mem[tidx_reg[TW-1:0]] <= wait_wd;
        end
        if (cmd.rd_tkey) begin
            tkey_q <= tkey_mem[tidx_reg[TW-1:0]];
        end
        if (cmd.rd_wait) begin
            wait_q <= wait_mem[cur_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rnew) begin
            rkey_mem[ridx_reg[RW-1:0]] <= key_reg;
        end
        if (own_we) begin
            own_mem[ridx_reg[RW-1:0]] <= own_wd;
        end
        if (cmd.rd_rkey) begin
            rkey_q <= rkey_mem[ridx_reg[RW-1:0]];
        end
        if (cmd.rd_own) begin
            own_q <= own_mem[wait_q[RW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_command;
            tid_reg <= in_thread_id;
            key_reg <= {in_resource_kind, in_resource_address};
        end
        if (cmd.cur_load) begin
            cur_reg <= tidx_reg[TW-1:0];
        end else if (cmd.walk_step) begin
            cur_reg <= own_q[TW-1:0];
        end
        if (cmd.res_load) begin
            deadlock_reg <= cmd.res_deadlock;
            status_reg   <= cmd.res_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcount_reg    <= '0;
            rcount_reg    <= '0;
            tidx_reg      <= '0;
            ridx_reg      <= '0;
            moves_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                tidx_reg <= '0;
                ridx_reg <= '0;
            end else begin
                if (cmd.tidx_inc) begin
                    tidx_reg <= tidx_reg + 1'b1;
                end
                if (cmd.ridx_inc) begin
                    ridx_reg <= ridx_reg + 1'b1;
                end
            end
            if (cmd.tnew) begin
                tcount_reg <= tcount_reg + 1'b1;
            end
            if (cmd.rnew) begin
                rcount_reg <= rcount_reg + 1'b1;
            end
            if (cmd.cur_load) begin
                moves_reg <= '0;
            end else if (cmd.walk_step) begin
                moves_reg <= moves_reg + 1'b1;
            end
            if (cmd.out_set) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.op         = op_reg;
        sts.tend       = (tidx_reg == tcount_reg);
        sts.tfull      = (tcount_reg == TCW'(THREADS));
        sts.tmatch     = (tkey_q == tid_reg);
        sts.rend       = (ridx_reg == rcount_reg);
        sts.rfull      = (rcount_reg == RCW'(RESOURCES));
        sts.rmatch     = (rkey_q == key_reg);
        sts.wait_act   = wait_q[RW];
        sts.own_act    = own_q[TW];
        sts.moves_done = (moves_reg == TCW'(THREADS));
        sts.out_busy   = out_valid_reg && !m_tready;
    end

    assign m_tvalid     = out_valid_reg;
    assign out_deadlock = deadlock_reg;
    assign out_status   = status_reg;

    a_tcount_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tcount_reg <= TCW'(THREADS))
        else $error("thread count beyond table size");
    a_rcount_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rcount_reg <= RCW'(RESOURCES))
        else $error("resource count beyond table size");
    a_tidx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tidx_reg <= tcount_reg)
        else $error("thread scan past fill count");
    a_out_set: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_set |=> out_valid_reg)
        else $error("result lost");

endmodule

// ===== rtl/wfgd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfgd_ctrl
// Sequencer for table scans, entry allocation, updates and the wait-chain
// walk of the deadlock detector.
// ----------------------------------------------------------------------------
module wfgd_ctrl
    import wfgd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  wfgd_sts_t sts,
    output wfgd_cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_T_RD  = 4'd1;
    localparam logic [3:0] S_T_CMP = 4'd2;
    localparam logic [3:0] S_R_RD  = 4'd3;
    localparam logic [3:0] S_R_CMP = 4'd4;
    localparam logic [3:0] S_M_RD  = 4'd5;
    localparam logic [3:0] S_ACQ   = 4'd6;
    localparam logic [3:0] S_W_RD  = 4'd7;
    localparam logic [3:0] S_W_CKW = 4'd8;
    localparam logic [3:0] S_W_CKO = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE) && !sts.out_busy;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && !sts.out_busy) begin
                    cmd.load   = 1'b1;
                    state_next = S_T_RD;
                end
            end
            S_T_RD: begin
                if (sts.op > OP_CHECK) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_DONE;
                end else if (sts.tend) begin
                    cmd.res_load = 1'b1;
                    if (sts.op == OP_CHECK) begin
                        cmd.res_status = ST_UNKNOWN;
                        state_next     = S_DONE;
                    end else if (sts.tfull) begin
                        cmd.res_status = ST_THR_FULL;
                        state_next     = S_DONE;
                    end else begin
                        cmd.tnew   = 1'b1;
                        state_next = (sts.op == OP_CLEAR) ? S_DONE : S_R_RD;
                    end
                end else begin
                    cmd.rd_tkey = 1'b1;
                    state_next  = S_T_CMP;
                end
            end
            S_T_CMP: begin
                if (!sts.tmatch) begin
                    cmd.tidx_inc = 1'b1;
                    state_next   = S_T_RD;
                end else if (sts.op == OP_CHECK) begin
                    cmd.cur_load = 1'b1;
                    state_next   = S_W_RD;
                end else if (sts.op == OP_CLEAR) begin
                    cmd.wait_clr = 1'b1;
                    cmd.res_load = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    state_next = S_R_RD;
                end
            end
            S_R_RD: begin
                if (sts.rend && sts.rfull) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_RES_FULL;
                    cmd.wait_clr   = (sts.op == OP_WAIT);
                    state_next     = S_DONE;
                end else if (sts.rend) begin
                    cmd.rnew     = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.wait_set = (sts.op == OP_WAIT);
                    cmd.own_clr  = (sts.op == OP_RELEASE);
                    cmd.cur_load = (sts.op == OP_ACQUIRE);
                    state_next   = (sts.op == OP_ACQUIRE) ? S_M_RD : S_DONE;
                end else begin
                    cmd.rd_rkey = 1'b1;
                    state_next  = S_R_CMP;
                end
            end
            S_R_CMP: begin
                if (!sts.rmatch) begin
                    cmd.ridx_inc = 1'b1;
                    state_next   = S_R_RD;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.wait_set = (sts.op == OP_WAIT);
                    cmd.own_clr  = (sts.op == OP_RELEASE);
                    cmd.cur_load = (sts.op == OP_ACQUIRE);
                    state_next   = (sts.op == OP_ACQUIRE) ? S_M_RD : S_DONE;
                end
            end
            S_M_RD: begin
                cmd.rd_wait = 1'b1;
                state_next  = S_ACQ;
            end
            S_ACQ: begin
                cmd.wait_clr_match = 1'b1;
                cmd.own_set        = 1'b1;
                state_next         = S_DONE;
            end
            S_W_RD: begin
                if (sts.moves_done) begin
                    cmd.res_load     = 1'b1;
                    cmd.res_deadlock = 1'b1;
                    state_next       = S_DONE;
                end else begin
                    cmd.rd_wait = 1'b1;
                    state_next  = S_W_CKW;
                end
            end
            S_W_CKW: begin
                if (!sts.wait_act) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.rd_own = 1'b1;
                    state_next = S_W_CKO;
                end
            end
            S_W_CKO: begin
                if (!sts.own_act) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_W_RD;
                end
            end
            S_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_set = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == S_T_RD)
        else $error("request load without scan start");
    a_write_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wait_set && cmd.wait_clr))
        else $error("conflicting wait writes");
    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_set |-> state_reg == S_DONE && $past(state_reg) != S_IDLE)
        else $error("result issued outside completion");

endmodule
